// ----- rtl/core/smap_pkg.sv -----
// Shared types and constants of the substitution map unit.
package smap_pkg;

  localparam int LETTERS = 26;
  localparam logic [4:0] UNKNOWN = 5'd26;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_QUESTION = 8'h3f;

  typedef enum logic [1:0] {
    MODE_TRANSLATE = 2'd0,
    MODE_PUSH      = 2'd1,
    MODE_POP       = 2'd2,
    MODE_NONE      = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_BUFFERED  = 3'd1,
    ST_REJECTED  = 3'd2,
    ST_POP_EMPTY = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_COPY,
    S_FILL,
    S_POP
  } state_t;

  function automatic logic is_upper(input logic [7:0] ch);
    return (ch >= 8'h41) && (ch <= 8'h5a);
  endfunction

  function automatic logic is_lower(input logic [7:0] ch);
    return (ch >= 8'h61) && (ch <= 8'h7a);
  endfunction

  // Letter index of a letter of either case; zero for any other byte.
  function automatic logic [4:0] letter_idx(input logic [7:0] ch);
    logic [7:0] d;
    d = 8'd0;
    if (is_upper(ch)) d = ch - CH_UPPER_A;
    else if (is_lower(ch)) d = ch - CH_LOWER_A;
    return d[4:0];
  endfunction

endpackage

// ----- rtl/core/smap_if.sv -----
// Handshake channels of the substitution map unit.
interface smap_item_if;
  import smap_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] cipher_char;
  logic [7:0] plain_char;
  logic       last_pair;

  modport source (output valid, mode, cipher_char, plain_char, last_pair, input ready);
  modport sink (input valid, mode, cipher_char, plain_char, last_pair, output ready);
endinterface

interface smap_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [2:0] status;

  modport source (output valid, out_char, status, input ready);
  modport sink (input valid, out_char, status, output ready);
endinterface

// ----- rtl/core/smap_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module smap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/substitution_map_with_undo_stack_unit.sv -----
// Substitution map with undo stack: translate items are done in the idle
// state, as are pairs of a push word that are not its last one and pops on
// an empty stack. The last pair of a word of L pairs replays the word buffer
// RAM once to check it; an accepted word then writes a 26-entry snapshot
// into the snapshot RAM and replays the buffer again to fill the map. A pop
// reads 26 entries back from the snapshot RAM. One item is in work at a
// time; a finished result waits in the output register, and the next item
// is accepted no earlier than the cycle in which that result transfers.
module substitution_map_with_undo_stack_unit
  import smap_pkg::*;
#(
  parameter int STACK_DEPTH = 16,
  parameter int MAX_WORD = 64
) (
  input logic clk,
  input logic rst,
  smap_item_if.sink     item,
  smap_result_if.source result
);

  localparam int WLEN_W = $clog2(MAX_WORD + 1);
  localparam int WADDR_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int CNT_W = (WLEN_W > 5) ? WLEN_W : 5;
  localparam int SCNT_W = $clog2(STACK_DEPTH + 1);
  localparam int SNAP_DEPTH = STACK_DEPTH * LETTERS;
  localparam int SADDR_W = (SNAP_DEPTH > 1) ? $clog2(SNAP_DEPTH) : 1;
  localparam int SBASE_W = $clog2(SNAP_DEPTH + 1);

  state_t state, state_next;
  logic [CNT_W-1:0]  cnt;
  logic              rd_v;
  logic [4:0]        pidx;
  logic              conflict;
  logic [SCNT_W-1:0] stack_count;
  logic [SBASE_W-1:0] snap_base;
  logic [WLEN_W-1:0] word_length;
  logic              word_rejected;
  logic [4:0]        map_table [LETTERS];
  logic              res_valid;
  logic [7:0]        res_char;
  status_t           res_status;

  logic       take;
  logic       ci_ok, pi_ok, len_room, rej_now;
  logic [4:0] ci, pi;
  logic       word_we;
  logic [9:0] word_rdata;
  logic       issue;
  logic       scan_done;
  logic       stack_full;
  logic       snap_we;
  logic [SBASE_W-1:0] snap_addr;
  logic [4:0] snap_rdata;
  logic [4:0] wc, wp, mc;
  logic [LETTERS-1:0] hits;
  logic       pair_bad;
  logic [7:0] xlat;

  assign item.ready = (state == S_IDLE) && (!res_valid || result.ready);
  assign take = item.valid && item.ready;
  assign result.valid = res_valid;
  assign result.out_char = res_char;
  assign result.status = res_status;

  assign ci_ok = is_upper(item.cipher_char) || is_lower(item.cipher_char);
  assign pi_ok = is_upper(item.plain_char) || is_lower(item.plain_char);
  assign ci = letter_idx(item.cipher_char);
  assign pi = letter_idx(item.plain_char);
  assign len_room = word_length < WLEN_W'(MAX_WORD);
  assign rej_now = word_rejected || !ci_ok || !pi_ok || !len_room;
  assign stack_full = stack_count == SCNT_W'(STACK_DEPTH);
  assign scan_done = (cnt == CNT_W'(word_length)) && !rd_v;

  // Check one replayed pair against the map as it stood before the word.
  assign wc = word_rdata[4:0];
  assign wp = word_rdata[9:5];
  assign mc = map_table[wc];
  always_comb begin
    for (int j = 0; j < LETTERS; j++) begin
      hits[j] = (map_table[j] == wp) && (5'(j) != wc);
    end
  end
  assign pair_bad = ((mc != UNKNOWN) && (mc != wp)) || (|hits);

  always_comb begin
    logic [4:0] v;
    v = map_table[letter_idx(item.cipher_char)];
    xlat = item.cipher_char;
    if (is_upper(item.cipher_char)) begin
      xlat = (v < UNKNOWN) ? CH_UPPER_A + 8'(v) : CH_QUESTION;
    end else if (is_lower(item.cipher_char)) begin
      xlat = (v < UNKNOWN) ? CH_LOWER_A + 8'(v) : CH_QUESTION;
    end
  end

  smap_ram #(.WIDTH(10), .DEPTH(MAX_WORD)) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_length[WADDR_W-1:0]),
    .wdata ({pi, ci}),
    .raddr (cnt[WADDR_W-1:0]),
    .rdata (word_rdata)
  );

  smap_ram #(.WIDTH(5), .DEPTH(SNAP_DEPTH)) u_snap_ram (
    .clk   (clk),
    .we    (snap_we),
    .waddr (snap_addr[SADDR_W-1:0]),
    .wdata (map_table[cnt[4:0]]),
    .raddr (snap_addr[SADDR_W-1:0]),
    .rdata (snap_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take && item.mode == MODE_PUSH && item.last_pair && !rej_now) begin
          state_next = S_CHECK;
        end else if (take && item.mode == MODE_POP && stack_count != '0) begin
          state_next = S_POP;
        end
      end
      S_CHECK: begin
        if (scan_done) state_next = (conflict || stack_full) ? S_IDLE : S_COPY;
      end
      S_COPY: begin
        if (cnt == CNT_W'(LETTERS - 1)) state_next = S_FILL;
      end
      S_FILL: begin
        if (scan_done) state_next = S_IDLE;
      end
      S_POP: begin
        if (cnt == CNT_W'(LETTERS) && !rd_v) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    word_we = take && item.mode == MODE_PUSH && len_room;
    issue = 1'b0;
    snap_we = 1'b0;
    unique case (state)
      S_CHECK, S_FILL: issue = cnt < CNT_W'(word_length);
      S_COPY:          snap_we = 1'b1;
      S_POP:           issue = cnt < CNT_W'(LETTERS);
      default:         issue = 1'b0;
    endcase
    snap_addr = snap_base + SBASE_W'(cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      rd_v <= 1'b0;
      conflict <= 1'b0;
      stack_count <= '0;
      snap_base <= '0;
      word_length <= '0;
      word_rejected <= 1'b0;
      res_valid <= 1'b0;
      for (int j = 0; j < LETTERS; j++) map_table[j] <= UNKNOWN;
    end else begin
      state <= state_next;
      rd_v <= issue;
      pidx <= cnt[4:0];
      if (result.ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          conflict <= 1'b0;
          if (take) begin
            res_valid <= 1'b1;
            res_char <= 8'd0;
            res_status <= ST_DONE;
            unique case (mode_t'(item.mode))
              MODE_TRANSLATE: res_char <= xlat;
              MODE_PUSH: begin
                if (len_room) word_length <= word_length + 1'b1;
                if (!item.last_pair) begin
                  word_rejected <= rej_now;
                  res_status <= ST_BUFFERED;
                end else if (rej_now) begin
                  // Drop the word at once.
                  word_length <= '0;
                  word_rejected <= 1'b0;
                  res_status <= ST_REJECTED;
                end else begin
                  res_valid <= 1'b0;
                end
              end
              MODE_POP: begin
                if (stack_count == '0) begin
                  res_status <= ST_POP_EMPTY;
                end else begin
                  res_valid <= 1'b0;
                  stack_count <= stack_count - 1'b1;
                  snap_base <= snap_base - SBASE_W'(LETTERS);
                end
              end
              MODE_NONE: res_char <= 8'd0;
              default: res_char <= 8'd0;
            endcase
          end
        end
        S_CHECK: begin
          if (issue) cnt <= cnt + 1'b1;
          if (rd_v && pair_bad) conflict <= 1'b1;
          if (scan_done) begin
            cnt <= '0;
            if (conflict || stack_full) begin
              res_valid <= 1'b1;
              res_char <= 8'd0;
              res_status <= conflict ? ST_REJECTED : ST_FULL;
              word_length <= '0;
            end
          end
        end
        S_COPY: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(LETTERS - 1)) begin
            cnt <= '0;
            stack_count <= stack_count + 1'b1;
            snap_base <= snap_base + SBASE_W'(LETTERS);
          end
        end
        S_FILL: begin
          if (issue) cnt <= cnt + 1'b1;
          if (rd_v && mc == UNKNOWN) map_table[wc] <= wp;
          if (scan_done) begin
            res_valid <= 1'b1;
            res_char <= 8'd0;
            res_status <= ST_DONE;
            word_length <= '0;
          end
        end
        S_POP: begin
          if (issue) cnt <= cnt + 1'b1;
          if (rd_v) map_table[pidx] <= snap_rdata;
          if (cnt == CNT_W'(LETTERS) && !rd_v) begin
            res_valid <= 1'b1;
            res_char <= 8'd0;
            res_status <= ST_DONE;
          end
        end
        default: cnt <= '0;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= SCNT_W'(STACK_DEPTH)) else $error("stack count overflow");
  a_base_tracks: assert property (@(posedge clk) disable iff (rst)
    32'(snap_base) == 32'(stack_count) * LETTERS) else $error("snapshot base drift");
  a_word_bound: assert property (@(posedge clk) disable iff (rst)
    word_length <= WLEN_W'(MAX_WORD)) else $error("word length overflow");
  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !item.ready) else $error("ready while busy");
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != ST_DONE |-> res_char == 8'd0) else $error("stray char");
`endif

endmodule
